[hdl/dmss_pkg.sv]
// shared types and constants for the descending merge sort block
// no dependencies; used by dmss_front, dmss_queue, dmss_back and the top level
package dmss_pkg;

  localparam int ID_BITS     = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // classification of one accepted item, made by the front
  typedef struct packed {
    logic keep;   // entry fits in the batch store
    logic last;   // entry closes the batch
  } item_flags_t;

  localparam int FLAG_BITS = $bits(item_flags_t);

endpackage

[hdl/dmss_front.sv]
// front end: accepts input transactions and classifies them as kept or dropped
// depends on dmss_pkg
module dmss_front #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_is_last,
  input  logic                  push_stall,
  output logic                  in_stall,
  output logic                  push_valid,
  output dmss_pkg::item_flags_t push_flags
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          accept;
  logic          keep;

  assign in_stall   = push_stall;
  assign push_valid = in_valid;
  assign accept     = in_valid && !push_stall;
  assign keep       = (count_r < CW'(MAX_ENTRIES));

  always_comb begin
    push_flags.keep = keep;
    push_flags.last = in_is_last;
  end

  // batch fill count as seen by the front, restarts after the closing item
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_is_last) begin
        count_nxt = '0;
      end else if (keep) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

[hdl/dmss_queue.sv]
// short register queue between the front and the sorting back end
// depends on dmss_pkg
module dmss_queue #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_stall,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_stall
);

  localparam int PW = dmss_pkg::QUEUE_PW;
  localparam int DEPTH = dmss_pkg::QUEUE_DEPTH;

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_stall = (cnt_r == (PW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = data_r[rd_ptr_r];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[hdl/dmss_back.sv]
// back end: loads the batch into a ping-pong store, merge sorts it bottom-up
// and streams the result out; depends on dmss_pkg
module dmss_back #(
  parameter int MAX_ENTRIES = 32,
  parameter int SCORE_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [SCORE_BITS-1:0]        q_score,
  input  logic [dmss_pkg::ID_BITS-1:0] q_id,
  input  dmss_pkg::item_flags_t        q_flags,
  output logic                         q_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SCORE_BITS-1:0]        out_sorted_score,
  output logic [dmss_pkg::ID_BITS-1:0] out_sorted_index,
  output logic                         out_last_out,
  output logic                         out_overflow
);

  localparam int IDB = dmss_pkg::ID_BITS;
  localparam int EW  = SCORE_BITS + IDB;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int MD  = 2 ** (AW + 1);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_MRD   = 7'b0000100,
    S_MCMP  = 7'b0001000,
    S_ERD   = 7'b0010000,
    S_ELD   = 7'b0100000,
    S_EWAIT = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic          bank_r, bank_nxt;   // bank holding the current runs
  logic [CW:0]   w_r, w_nxt;         // run width of the current pass
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [CW-1:0] b_r, b_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic [EW-1:0] mem [MD];
  logic [EW-1:0] rd_a_r, rd_b_r;
  logic [AW:0]   rd_addr_a, rd_addr_b, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic                  out_valid_r, out_valid_nxt;
  logic [SCORE_BITS-1:0] out_score_r;
  logic [IDB-1:0]        out_id_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic          pop;
  logic [CW-1:0] n_inc, k_inc;
  logic [CW+1:0] sum_mid, sum_hi, n_ext;
  logic [CW-1:0] mid_calc, hi_calc;
  logic          a_ok, b_ok, take_a;
  logic [SCORE_BITS-1:0] score_a, score_b;

  assign q_stall = (state_r != S_LOAD);
  assign pop     = q_valid && (state_r == S_LOAD);
  assign n_inc   = n_r + 1'b1;
  assign k_inc   = k_r + 1'b1;

  // bounds of the next merge: [lo, mid) and [mid, hi), clipped to the batch
  assign n_ext    = {2'b00, n_r};
  assign sum_mid  = {2'b00, lo_r} + {1'b0, w_r};
  assign sum_hi   = {2'b00, lo_r} + {w_r, 1'b0};
  assign mid_calc = (sum_mid > n_ext) ? n_r : sum_mid[CW-1:0];
  assign hi_calc  = (sum_hi  > n_ext) ? n_r : sum_hi[CW-1:0];

  assign score_a = rd_a_r[EW-1:IDB];
  assign score_b = rd_b_r[EW-1:IDB];
  assign a_ok    = (a_r < mid_r);
  assign b_ok    = (b_r < hi_r);
  // right head wins on equal scores
  assign take_a  = a_ok && (!b_ok || (score_a > score_b));

  assign rd_addr_a = (state_r == S_ERD) ? {bank_r, k_r[AW-1:0]} : {bank_r, a_r[AW-1:0]};
  assign rd_addr_b = {bank_r, b_r[AW-1:0]};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {1'b0, n_r[AW-1:0]};
    wr_data = {q_score, q_id};
    if (pop && q_flags.keep) begin
      wr_en = 1'b1;
    end else if (state_r == S_MCMP) begin
      wr_en   = 1'b1;
      wr_addr = {~bank_r, k_r[AW-1:0]};
      wr_data = take_a ? rd_a_r : rd_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    bank_nxt      = bank_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_LOAD: begin
        if (pop) begin
          if (q_flags.keep) begin
            n_nxt = n_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_flags.last) begin
            w_nxt    = (CW+1)'(1);
            lo_nxt   = '0;
            k_nxt    = '0;
            bank_nxt = 1'b0;
            // a single entry needs no merge pass
            if ((q_flags.keep ? n_inc : n_r) > CW'(1)) begin
              state_nxt = S_SETUP;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_SETUP: begin
        mid_nxt   = mid_calc;
        hi_nxt    = hi_calc;
        a_nxt     = lo_r;
        b_nxt     = mid_calc;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        if (take_a) begin
          a_nxt = a_r + 1'b1;
        end else begin
          b_nxt = b_r + 1'b1;
        end
        if (k_inc == hi_r) begin
          if (hi_r == n_r) begin
            // pass done: swap banks and double the run width
            bank_nxt = ~bank_r;
            w_nxt    = {w_r[CW-1:0], 1'b0};
            lo_nxt   = '0;
            k_nxt    = '0;
            if ({w_r, 1'b0} >= n_ext) begin
              state_nxt = S_ERD;
            end else begin
              state_nxt = S_SETUP;
            end
          end else begin
            lo_nxt    = hi_r;
            k_nxt     = k_inc;
            state_nxt = S_SETUP;
          end
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_MRD;
        end
      end
      S_ERD: begin
        state_nxt = S_ELD;
      end
      S_ELD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            n_nxt     = '0;
            ovf_nxt   = 1'b0;
            bank_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ELD) begin
      out_score_r <= score_a;
      out_id_r    <= rd_a_r[IDB-1:0];
      out_last_r  <= (k_inc == n_r);
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      bank_r      <= 1'b0;
      w_r         <= '0;
      lo_r        <= '0;
      mid_r       <= '0;
      hi_r        <= '0;
      a_r         <= '0;
      b_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      ovf_r       <= ovf_nxt;
      bank_r      <= bank_nxt;
      w_r         <= w_nxt;
      lo_r        <= lo_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_score = out_score_r;
  assign out_sorted_index = out_id_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

[hdl/descending_merge_sort_by_score.sv]
// top level of the descending merge sort: front, queue and sorting back end
// depends on dmss_pkg, dmss_front, dmss_queue and dmss_back
//
//   channel   ports                                     direction  handshake
//   in        in_score, in_entry_index, in_is_last      input      in_valid / in_stall
//   out       out_sorted_score, out_sorted_index,       output     out_valid / out_stall
//             out_last_out, out_overflow
//
// items enter the queue at one per cycle while the queue is not full; the back end
// drains it at one per cycle while loading. after the closing item the batch of n
// entries is sorted in ceil(log2 n) passes; each merge opens with a setup step and
// each entry is written by a read step and the single compare-and-write step against
// the two-read-port store. results leave one at a time, each held until out_stall is
// low. reset is synchronous, active low, and empties the queue and batch. out_stall
// holds the current result; in_stall rises only when the queue is full.
module descending_merge_sort_by_score #(
  parameter int MAX_ENTRIES = 32,
  parameter int SCORE_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SCORE_BITS-1:0]        in_score,
  input  logic [dmss_pkg::ID_BITS-1:0] in_entry_index,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SCORE_BITS-1:0]        out_sorted_score,
  output logic [dmss_pkg::ID_BITS-1:0] out_sorted_index,
  output logic                         out_last_out,
  output logic                         out_overflow
);

  localparam int IDB = dmss_pkg::ID_BITS;
  localparam int QW  = SCORE_BITS + IDB + dmss_pkg::FLAG_BITS;

  logic                  push_valid, push_stall;
  dmss_pkg::item_flags_t push_flags, pop_flags;
  logic [QW-1:0]         push_data, pop_data;
  logic                  pop_valid, pop_stall;

  dmss_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .push_stall (push_stall),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_flags (push_flags)
  );

  assign push_data = {in_score, in_entry_index, push_flags};

  dmss_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_data  (push_data),
    .wr_stall (push_stall),
    .rd_valid (pop_valid),
    .rd_data  (pop_data),
    .rd_stall (pop_stall)
  );

  assign pop_flags = dmss_pkg::item_flags_t'(pop_data[dmss_pkg::FLAG_BITS-1:0]);

  dmss_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCORE_BITS  (SCORE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (pop_valid),
    .q_score          (pop_data[QW-1:IDB+dmss_pkg::FLAG_BITS]),
    .q_id             (pop_data[IDB+dmss_pkg::FLAG_BITS-1:dmss_pkg::FLAG_BITS]),
    .q_flags          (pop_flags),
    .q_stall          (pop_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_score (out_sorted_score),
    .out_sorted_index (out_sorted_index),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule
